FILE: rtl/csim_pkg.sv
// Shared constants, codes and helpers for the set-associative LRU cache model.
package csim_pkg;

	// Default sizing handed to the top-level parameters
	localparam int DEF_MAX_SETS  = 16;
	localparam int DEF_MAX_WAYS  = 4;
	localparam int DEF_ADDR_BITS = 64;

	// Fixed field widths
	localparam int ADDR_W    = 64;
	localparam int CNT_W     = 32;
	localparam int STAMP_W   = 64;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;

	// Register reset values
	localparam logic [2:0] RST_SET_BITS   = 3'd4;
	localparam logic [2:0] RST_WAYS       = 3'd1;
	localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_STORE,
		CMD_MODIFY,
		CMD_NONE
	} cmd_t;

	typedef enum logic [1:0] {
		RES_HIT,
		RES_MISS,
		RES_EVICT
	} outcome_t;

	typedef enum logic [1:0] {
		REG_SET_BITS,
		REG_WAYS,
		REG_BLOCK_BITS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_RESOLVE,
		ST_SECOND,
		ST_FINISH
	} state_t;

	// Saturating increment for 32-bit totals
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
		return (&x) ? x : x + 1'b1;
	endfunction

endpackage

FILE: rtl/csim_decode.sv
// Address capture and split into set index and tag (shift unit).
module csim_decode import csim_pkg::*; #(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1,
	localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic [ADDR_W-1:0]    address,
	input  logic [2:0]           set_bits,
	input  logic [5:0]           block_bits,
	output logic [SET_W-1:0]     set_idx,
	output logic [ADDR_BITS-1:0] tag
);

	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] set_full;
	logic [2:0]           sb;
	logic [6:0]           top;

	// Hold the address of the transaction in flight
	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= address[ADDR_BITS-1:0];
		end
	end

	// Clamp set bits to the store size, then shift out offset and index
	always_comb begin
		sb = (int'(set_bits) > LOG_SETS) ? 3'(LOG_SETS) : set_bits;
		set_full = addr_q >> block_bits;
		for (int i = 0; i < SET_W; i++) begin
			set_idx[i] = set_full[i] & (i < int'(sb));
		end
		top = 7'(block_bits) + 7'(sb);
		// offset plus index reaching bit 64 leaves no tag
		tag = top[6] ? '0 : (addr_q >> top[5:0]);
	end

endmodule

FILE: rtl/csim_store.sv
// Line store: tag and access-stamp memory with per-line valid flops.
module csim_store import csim_pkg::*; #(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	localparam int LINES    = MAX_SETS * MAX_WAYS,
	localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [LINE_W-1:0]    rd_idx,
	output logic                 rd_valid,
	output logic [ADDR_BITS-1:0] rd_tag,
	output logic [STAMP_W-1:0]   rd_stamp,
	input  logic                 wr_en,
	input  logic [LINE_W-1:0]    wr_idx,
	input  logic [ADDR_BITS-1:0] wr_tag,
	input  logic [STAMP_W-1:0]   wr_stamp
);

	logic [ADDR_BITS-1:0] tag_mem   [LINES];
	logic [STAMP_W-1:0]   stamp_mem [LINES];
	logic [LINES-1:0]     valid_q;
	logic                 rd_valid_q;
	logic [ADDR_BITS-1:0] rd_tag_q;
	logic [STAMP_W-1:0]   rd_stamp_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_idx]   <= wr_tag;
			stamp_mem[wr_idx] <= wr_stamp;
		end
		if (rd_en) begin
			rd_tag_q   <= tag_mem[rd_idx];
			rd_stamp_q <= stamp_mem[rd_idx];
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	// Valid bits clear at reset, set on fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_tag   = rd_tag_q;
	assign rd_stamp = rd_stamp_q;

endmodule

FILE: rtl/csim_seq.sv
// Access sequencer: way scan with a shared compare/age unit, replacement, totals.
module csim_seq import csim_pkg::*; #(
	parameter int MAX_SETS   = DEF_MAX_SETS,
	parameter int MAX_WAYS   = DEF_MAX_WAYS,
	parameter int ADDR_BITS  = DEF_ADDR_BITS,
	localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1),
	localparam int LINES     = MAX_SETS * MAX_WAYS,
	localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [WAY_CNT_W-1:0] n_ways,
	output logic                 dec_load,
	input  logic [SET_W-1:0]     dec_set,
	input  logic [ADDR_BITS-1:0] dec_tag,
	output logic                 rd_en,
	output logic [LINE_W-1:0]    rd_idx,
	input  logic                 rd_valid,
	input  logic [ADDR_BITS-1:0] rd_tag,
	input  logic [STAMP_W-1:0]   rd_stamp,
	output logic                 wr_en,
	output logic [LINE_W-1:0]    wr_idx,
	output logic [ADDR_BITS-1:0] wr_tag,
	output logic [STAMP_W-1:0]   wr_stamp,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           outcome,
	output logic                 second_hit,
	output logic [CNT_W-1:0]     hit_total,
	output logic [CNT_W-1:0]     miss_total,
	output logic [CNT_W-1:0]     eviction_total
);

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [SET_W-1:0]     set_q;
	logic [ADDR_BITS-1:0] tag_q;
	logic [WAY_CNT_W-1:0] way_q;
	logic                 pend_q;
	logic [WAY_W-1:0]     pway_q;
	logic                 hit_q, inv_q;
	logic [WAY_W-1:0]     hit_way_q, inv_way_q, vict_q;
	logic [CNT_W-1:0]     best_q;
	outcome_t             res_q;
	logic                 second_q;
	logic [STAMP_W-1:0]   now_q;
	logic [CNT_W-1:0]     hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic                 out_valid_q;
	logic [1:0]           outcome_q;
	logic                 second_hit_q;
	logic [CNT_W-1:0]     hit_total_q, miss_total_q, evict_total_q;

	logic                 issue, out_free, fin_fire;
	logic [STAMP_W-1:0]   age_diff;
	logic [CNT_W-1:0]     age;
	logic [WAY_W-1:0]     wr_way;

	// Age of the line just read: items since its last access, saturated
	assign age_diff = now_q - rd_stamp;
	assign age      = (|age_diff[STAMP_W-1:CNT_W]) ? '1 : age_diff[CNT_W-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign dec_load = in_valid && in_ready;

	// Victim priority: hit way, then first empty way, then oldest way
	always_comb begin
		priority if (hit_q) begin
			wr_way = hit_way_q;
		end else if (inv_q) begin
			wr_way = inv_way_q;
		end else begin
			wr_way = vict_q;
		end
	end

	assign rd_idx   = LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(way_q[WAY_W-1:0]);
	assign wr_idx   = LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(wr_way);
	assign wr_tag   = tag_q;
	assign wr_stamp = now_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_DECODE;
			ST_DECODE:  state_d = (cmd_q == CMD_NONE) ? ST_FINISH : ST_SCAN;
			ST_SCAN:    if (!issue) state_d = ST_RESOLVE;
			ST_RESOLVE: state_d = (cmd_q == CMD_MODIFY) ? ST_SECOND : ST_FINISH;
			ST_SECOND:  state_d = ST_FINISH;
			ST_FINISH:  if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue    = (state_q == ST_SCAN) && (way_q < n_ways);
		rd_en    = issue;
		wr_en    = (state_q == ST_RESOLVE);
		fin_fire = (state_q == ST_FINISH) && out_free;
	end

	// Control state, totals and item clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			way_q       <= '0;
			pend_q      <= 1'b0;
			hit_q       <= 1'b0;
			inv_q       <= 1'b0;
			now_q       <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DECODE: begin
					way_q  <= '0;
					pend_q <= 1'b0;
					hit_q  <= 1'b0;
					inv_q  <= 1'b0;
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) way_q <= way_q + 1'b1;
					if (pend_q) begin
						if (rd_valid && (rd_tag == tag_q)) hit_q <= 1'b1;
						if (!rd_valid) inv_q <= 1'b1;
					end
				end
				ST_RESOLVE: begin
					priority if (hit_q) begin
						hit_cnt_q <= sat_inc(hit_cnt_q);
					end else if (inv_q) begin
						miss_cnt_q <= sat_inc(miss_cnt_q);
					end else begin
						miss_cnt_q  <= sat_inc(miss_cnt_q);
						evict_cnt_q <= sat_inc(evict_cnt_q);
					end
				end
				// store half of a modify always hits
				ST_SECOND: hit_cnt_q <= sat_inc(hit_cnt_q);
				ST_FINISH: if (fin_fire) now_q <= now_q + 1'b1;
				default: ;
			endcase
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction payload and scan tracking
	always_ff @(posedge clk) begin
		if (dec_load) begin
			cmd_q    <= cmd_t'(command);
			res_q    <= RES_HIT;
			second_q <= 1'b0;
		end
		if (state_q == ST_DECODE) begin
			set_q <= dec_set;
			tag_q <= dec_tag;
		end
		if (issue) begin
			pway_q <= way_q[WAY_W-1:0];
		end
		if ((state_q == ST_SCAN) && pend_q) begin
			if (rd_valid && (rd_tag == tag_q) && !hit_q) hit_way_q <= pway_q;
			if (!rd_valid && !inv_q) inv_way_q <= pway_q;
			// strictly older wins, so a tie keeps the lower way
			if ((pway_q == '0) || (age > best_q)) begin
				best_q <= age;
				vict_q <= pway_q;
			end
		end
		if (state_q == ST_RESOLVE) begin
			priority if (hit_q) begin
				res_q <= RES_HIT;
			end else if (inv_q) begin
				res_q <= RES_MISS;
			end else begin
				res_q <= RES_EVICT;
			end
		end
		if (state_q == ST_SECOND) begin
			second_q <= 1'b1;
		end
		if (fin_fire) begin
			outcome_q     <= res_q;
			second_hit_q  <= second_q;
			hit_total_q   <= hit_cnt_q;
			miss_total_q  <= miss_cnt_q;
			evict_total_q <= evict_cnt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign outcome        = outcome_q;
	assign second_hit     = second_hit_q;
	assign hit_total      = hit_total_q;
	assign miss_total     = miss_total_q;
	assign eviction_total = evict_total_q;

	// Store is written only after the scan has fully drained
	a_wr_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == ST_RESOLVE) && !pend_q))
		else $error("line write outside resolve or with read pending");

	// Scan never issues past the ways in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (way_q <= n_ways))
		else $error("way scan overran");

	// Eviction counted only when no way hit and none was empty
	a_evict_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(evict_cnt_q != $past(evict_cnt_q)) |->
		(($past(state_q) == ST_RESOLVE) && !$past(hit_q) && !$past(inv_q)))
		else $error("eviction counted without a full-set miss");

	// Lines age once per result, no more
	a_age_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(now_q != $past(now_q)) |-> $past(fin_fire))
		else $error("item clock moved without a result");

	// An accepted transaction goes straight to decode
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		dec_load |=> (state_q == ST_DECODE))
		else $error("accepted transaction not decoded");

endmodule

FILE: rtl/set_assoc_lru_cache_sim.sv
// Set-associative cache model with LRU replacement: top level and configuration registers.
//
// Each transaction is one load, store or modify at a 64-bit byte address. The address is split
// into block offset, set index and tag by the block_bits and set_bits registers, the ways of the
// set are read one per cycle from a line memory with one read and one write port and checked
// against the tag, and the line is then refreshed, filled or replaced (oldest way, lowest way on
// a tie). A modify adds a second step, the store half, which always hits; command code three
// makes no access. Line ages are kept as access stamps against a running transaction count, so
// aging all lines costs nothing per transaction. A finished result waits in an output register
// while the next transaction is accepted. Valid bits clear at reset with no sweep. Configuration
// writes are taken at any time but must only happen while the block is idle.
module set_assoc_lru_cache_sim import csim_pkg::*; #(
	parameter int MAX_SETS   = DEF_MAX_SETS,
	parameter int MAX_WAYS   = DEF_MAX_WAYS,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [ADDR_W-1:0]    address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           outcome,
	output logic                 second_hit,
	output logic [CNT_W-1:0]     hit_total,
	output logic [CNT_W-1:0]     miss_total,
	output logic [CNT_W-1:0]     eviction_total
);

	localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
	localparam int LINES     = MAX_SETS * MAX_WAYS;
	localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;

	logic [2:0]           set_bits_q;
	logic [2:0]           ways_q;
	logic [5:0]           block_bits_q;
	logic [WAY_CNT_W-1:0] n_ways;

	logic                 dec_load;
	logic [SET_W-1:0]     dec_set;
	logic [ADDR_BITS-1:0] dec_tag;
	logic                 rd_en, rd_valid, wr_en;
	logic [LINE_W-1:0]    rd_idx, wr_idx;
	logic [ADDR_BITS-1:0] rd_tag, wr_tag;
	logic [STAMP_W-1:0]   rd_stamp, wr_stamp;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= RST_SET_BITS;
			ways_q       <= RST_WAYS;
			block_bits_q <= RST_BLOCK_BITS;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				REG_WAYS:       ways_q       <= cfg_data[2:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ways in use: zero acts as one, clamp to the built size
	always_comb begin
		priority if (ways_q == '0) begin
			n_ways = WAY_CNT_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			n_ways = WAY_CNT_W'(MAX_WAYS);
		end else begin
			n_ways = WAY_CNT_W'(ways_q);
		end
	end

	csim_decode #(
		.MAX_SETS  (MAX_SETS),
		.ADDR_BITS (ADDR_BITS)
	) u_decode (
		.clk        (clk),
		.load       (dec_load),
		.address    (address),
		.set_bits   (set_bits_q),
		.block_bits (block_bits_q),
		.set_idx    (dec_set),
		.tag        (dec_tag)
	);

	csim_store #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx),
		.rd_valid (rd_valid),
		.rd_tag   (rd_tag),
		.rd_stamp (rd_stamp),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_tag   (wr_tag),
		.wr_stamp (wr_stamp)
	);

	csim_seq #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.n_ways         (n_ways),
		.dec_load       (dec_load),
		.dec_set        (dec_set),
		.dec_tag        (dec_tag),
		.rd_en          (rd_en),
		.rd_idx         (rd_idx),
		.rd_valid       (rd_valid),
		.rd_tag         (rd_tag),
		.rd_stamp       (rd_stamp),
		.wr_en          (wr_en),
		.wr_idx         (wr_idx),
		.wr_tag         (wr_tag),
		.wr_stamp       (wr_stamp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outcome        (outcome),
		.second_hit     (second_hit),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

endmodule
